@@ hdl/cge_pkg.sv @@
// cge_pkg: constants, types and the 2^-x lookup table shared by the
// circular Gaussian evaluator modules. No dependencies.
`timescale 1ns / 1ps

package cge_pkg;

  // field widths
  localparam int COORD_W         = 16;
  localparam int COORD_FRAC_BITS = 4;
  localparam int AMP_W           = 16;
  localparam int SIGMA_W         = 16;
  localparam int VAL_W           = 16;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_X_CENTER    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_Y_CENTER    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SIGMA = CFG_IDX_W'(3);

  localparam logic [AMP_W-1:0]   AMP_RESET   = AMP_W'(256);
  localparam logic [SIGMA_W-1:0] SIGMA_RESET = SIGMA_W'(256);

  // distance and exponent argument
  localparam int SQ_W         = 2 * COORD_W;
  localparam int R2_W         = SQ_W + 1;
  localparam int SS_W         = 2 * SIGMA_W;
  localparam int DEN_W        = SS_W + 1;
  localparam int Q_FRAC       = 16;
  localparam int NUM_SHIFT    = Q_FRAC - 2 * COORD_FRAC_BITS;
  localparam int NUM_W        = R2_W + NUM_SHIFT;
  localparam int T_LIMIT_BITS = 4;
  localparam int QUOT_W       = T_LIMIT_BITS + Q_FRAC;
  localparam int CMP_W        = (NUM_W > DEN_W + T_LIMIT_BITS) ? NUM_W + 1
                                                               : DEN_W + T_LIMIT_BITS + 1;

  // base-2 conversion
  localparam int                  LOG2E_W   = 17;
  localparam logic [LOG2E_W-1:0]  LOG2E_Q16 = LOG2E_W'(94548);
  localparam int                  PRODU_W   = QUOT_W + LOG2E_W;
  localparam int                  U_W       = PRODU_W - Q_FRAC;
  localparam int                  K_W       = U_W - Q_FRAC;

  // exp table
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_FRAC_BITS   = 30;
  localparam int TAB_W           = EXP_FRAC_BITS + 1;
  localparam int SERIES_TERMS    = 24;
  localparam longint unsigned LN2_Q30 = 64'd744261118;
  localparam longint unsigned ONE_Q30 = 64'd1 << EXP_FRAC_BITS;

  // output scaling
  localparam int PROD_W = AMP_W + TAB_W;
  localparam int SH_W   = $clog2(EXP_FRAC_BITS + (1 << K_W));
  localparam int Q1_W   = VAL_W + 1;

  typedef logic [TAB_W-1:0] exp_tab_t [0:EXP_TABLE_DEPTH];

  typedef struct packed {
    logic [DEN_W-1:0]        rem;
    logic [DEN_W-1:0]        den;
    logic [T_LIMIT_BITS-1:0] lowb;
    logic                    far;
  } cge_div_in_t;

  // exp(-j*ln2/depth) in Q30, truncated Taylor series
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t        tab;
    longint unsigned y;
    longint unsigned term;
    longint          sum;
    for (int j = 0; j <= EXP_TABLE_DEPTH; j++) begin
      y    = (64'(j) * LN2_Q30 + 64'(EXP_TABLE_DEPTH / 2)) / 64'(EXP_TABLE_DEPTH);
      sum  = longint'(ONE_Q30);
      term = ONE_Q30;
      for (int n = 1; n <= SERIES_TERMS; n++) begin
        term = ((term * y) >> EXP_FRAC_BITS) / 64'(n);
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      tab[j] = TAB_W'(sum);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

@@ hdl/cge_divider.sv @@
// cge_divider: pipelined restoring divider, one quotient bit per stage,
// giving floor((num << 16) / den). Depends on cge_pkg.
`timescale 1ns / 1ps

module cge_divider import cge_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  cge_div_in_t       din_i,
  output logic              valid_o,
  output logic [QUOT_W-1:0] quot_o,
  output logic              far_o
);

  cge_div_in_t       stg_q  [QUOT_W];
  logic [QUOT_W-1:0] quot_q [QUOT_W];
  logic              vld_q  [QUOT_W];

  for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
    cge_div_in_t       src;
    logic [QUOT_W-1:0] quot_src;
    logic              vld_src;
    logic              nbit;
    logic [DEN_W:0]    cand;
    logic              ge;
    cge_div_in_t       stg_d;
    logic [QUOT_W-1:0] quot_d;

    if (j == 0) begin : g_first
      assign src      = din_i;
      assign quot_src = '0;
      assign vld_src  = valid_i;
    end else begin : g_next
      assign src      = stg_q[j-1];
      assign quot_src = quot_q[j-1];
      assign vld_src  = vld_q[j-1];
    end

    // dividend bits below the initial remainder, then zeros
    if (j < T_LIMIT_BITS) begin : g_num
      assign nbit = src.lowb[T_LIMIT_BITS-1-j];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign cand   = {src.rem, nbit};
    assign ge     = (cand >= {1'b0, src.den});
    assign quot_d = {quot_src[QUOT_W-2:0], ge};

    always_comb begin
      stg_d     = src;
      stg_d.rem = ge ? DEN_W'(cand - {1'b0, src.den}) : cand[DEN_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[j]  <= stg_d;
        quot_q[j] <= quot_d;
      end
    end
  end

  assign valid_o = vld_q[QUOT_W-1];
  assign quot_o  = quot_q[QUOT_W-1];
  assign far_o   = stg_q[QUOT_W-1].far;

endmodule

@@ hdl/cge_exp2.sv @@
// cge_exp2: turns the exponent argument into amplitude * exp(-t) with
// base-2 range reduction, table lookup and interpolation. Depends on cge_pkg.
`timescale 1ns / 1ps

module cge_exp2 import cge_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic              far_i,
  input  logic [QUOT_W-1:0] t_i,
  input  logic [AMP_W-1:0]  amp_i,
  output logic              valid_o,
  output logic [VAL_W-1:0]  val_o
);

  localparam int STAGES = 8;

  logic [STAGES-1:0] vld_q;
  logic [STAGES-1:0] far_q;

  // stage 1: t * log2(e)
  logic [PRODU_W-1:0] produ_q;
  // stage 2: split into shift, index and weight
  logic [PRODU_W-1:0] usum;
  logic [U_W-1:0]     u;
  logic [Q_FRAC-1:0]  f;
  logic [K_W-1:0]     k2_q;
  logic [IDX_W-1:0]   idx2_q;
  logic [Q_FRAC-1:0]  wt2_q;
  // stage 3: table reads
  logic [TAB_W-1:0]   hi3_q;
  logic [TAB_W-1:0]   lo3_q;
  logic [K_W-1:0]     k3_q;
  logic [Q_FRAC-1:0]  wt3_q;
  // stage 4: slope
  logic [TAB_W-1:0]   diff4_q;
  logic [TAB_W-1:0]   hi4_q;
  logic               up4_q;
  logic [K_W-1:0]     k4_q;
  logic [Q_FRAC-1:0]  wt4_q;
  // stage 5: slope * weight
  logic [TAB_W+Q_FRAC-1:0] dw_full;
  logic [TAB_W-1:0]   dw5_q;
  logic [TAB_W-1:0]   hi5_q;
  logic               up5_q;
  logic [K_W-1:0]     k5_q;
  // stage 6: interpolated mantissa
  logic [TAB_W-1:0]   m6_q;
  logic [K_W-1:0]     k6_q;
  // stage 7: amplitude product
  logic [PROD_W-1:0]  prod7_q;
  logic [K_W-1:0]     k7_q;
  // stage 8: shift
  logic [SH_W-1:0]    sh;
  logic [Q1_W-1:0]    q1_8_q;
  logic [Q1_W:0]      rnd;

  assign usum = produ_q + PRODU_W'(1 << (Q_FRAC - 1));
  assign u    = usum[PRODU_W-1:Q_FRAC];
  assign f    = u[Q_FRAC-1:0];

  assign dw_full = (TAB_W+Q_FRAC)'(diff4_q) * (TAB_W+Q_FRAC)'(wt4_q);

  assign sh = SH_W'(EXP_FRAC_BITS - 1) + SH_W'(k7_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      far_q   <= {far_q[STAGES-2:0], far_i};

      produ_q <= PRODU_W'(t_i) * PRODU_W'(LOG2E_Q16);

      k2_q    <= u[U_W-1:Q_FRAC];
      idx2_q  <= f[Q_FRAC-1 -: IDX_W];
      wt2_q   <= f << IDX_W;

      hi3_q   <= EXP_TAB[(IDX_W+1)'(idx2_q)];
      lo3_q   <= EXP_TAB[(IDX_W+1)'(idx2_q) + (IDX_W+1)'(1)];
      k3_q    <= k2_q;
      wt3_q   <= wt2_q;

      diff4_q <= (hi3_q >= lo3_q) ? hi3_q - lo3_q : lo3_q - hi3_q;
      up4_q   <= (lo3_q > hi3_q);
      hi4_q   <= hi3_q;
      k4_q    <= k3_q;
      wt4_q   <= wt3_q;

      dw5_q   <= dw_full[TAB_W+Q_FRAC-1:Q_FRAC];
      hi5_q   <= hi4_q;
      up5_q   <= up4_q;
      k5_q    <= k4_q;

      m6_q    <= up5_q ? hi5_q + dw5_q : hi5_q - dw5_q;
      k6_q    <= k5_q;

      prod7_q <= PROD_W'(amp_i) * PROD_W'(m6_q);
      k7_q    <= k6_q;

      q1_8_q  <= Q1_W'(prod7_q >> sh);
    end
  end

  // round half up: shifted one bit short, add one, drop the bit
  assign rnd     = (Q1_W+1)'(q1_8_q) + (Q1_W+1)'(1);
  assign valid_o = vld_q[STAGES-1];
  assign val_o   = far_q[STAGES-1] ? '0 : rnd[VAL_W:1];

endmodule

@@ hdl/circular_gaussian_eval.sv @@
// circular_gaussian_eval: amplitude * exp(-r^2 / (2 sigma^2)) per pixel item
// pipeline from s_axis accept to m_axis_tvalid: 4 distance stages, 20 divider
// stages at one quotient bit each, 8 exp stages and an output register
// throughput: one item per cycle; a stalled output holds the pipeline only
// once its last stage is occupied
// reset: clears all valid bits and loads the register defaults
`timescale 1ns / 1ps

module circular_gaussian_eval import cge_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*COORD_W-1:0]  s_axis_tdata,   // pos_x, pos_y
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [VAL_W-1:0]      m_axis_tdata,   // value
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [COORD_W-1:0] x_center_q;
  logic [COORD_W-1:0] y_center_q;
  logic [AMP_W-1:0]   amplitude_q;
  logic [SIGMA_W-1:0] width_sigma_q;

  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [COORD_W-1:0] dx_d;
  logic [COORD_W-1:0] dy_d;
  logic [SIGMA_W-1:0] sigma_eff;

  logic               v1_q, v2_q, v3_q, v4_q;
  logic [COORD_W-1:0] dx_q, dy_q;
  logic [SQ_W-1:0]    sqx_q, sqy_q;
  logic [SS_W-1:0]    ss_q;
  logic [R2_W-1:0]    r2_q;
  logic [DEN_W-1:0]   den_q;
  logic [NUM_W-1:0]   num;
  logic [CMP_W-1:0]   num_ext;
  logic [CMP_W-1:0]   lim_ext;
  cge_div_in_t        div_in_d;
  cge_div_in_t        div_in_q;

  logic               div_valid;
  logic [QUOT_W-1:0]  div_quot;
  logic               div_far;
  logic               exp_valid;
  logic [VAL_W-1:0]   exp_val;

  logic               out_free;
  logic               pipe_en;
  logic               m_valid_q;
  logic               m_valid_d;
  logic [VAL_W-1:0]   m_data_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_center_q    <= '0;
      y_center_q    <= '0;
      amplitude_q   <= AMP_RESET;
      width_sigma_q <= SIGMA_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_X_CENTER:    x_center_q    <= COORD_W'(cfg_data_i);
        REG_Y_CENTER:    y_center_q    <= COORD_W'(cfg_data_i);
        REG_AMPLITUDE:   amplitude_q   <= AMP_W'(cfg_data_i);
        REG_WIDTH_SIGMA: width_sigma_q <= SIGMA_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // flow control
  assign out_free      = !m_valid_q || m_axis_tready;
  assign pipe_en       = out_free || !exp_valid;
  assign s_axis_tready = pipe_en;

  // distance front end
  assign pos_x     = s_axis_tdata[COORD_W-1:0];
  assign pos_y     = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign dx_d      = (pos_x >= x_center_q) ? pos_x - x_center_q : x_center_q - pos_x;
  assign dy_d      = (pos_y >= y_center_q) ? pos_y - y_center_q : y_center_q - pos_y;
  assign sigma_eff = (width_sigma_q == '0) ? SIGMA_W'(1) : width_sigma_q;

  assign num     = NUM_W'(r2_q) << NUM_SHIFT;
  assign num_ext = CMP_W'(num);
  assign lim_ext = CMP_W'({den_q, T_LIMIT_BITS'(0)});

  always_comb begin
    div_in_d.rem  = DEN_W'(num >> T_LIMIT_BITS);
    div_in_d.den  = den_q;
    div_in_d.lowb = num[T_LIMIT_BITS-1:0];
    div_in_d.far  = (num_ext >= lim_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      sqx_q    <= SQ_W'(dx_q) * SQ_W'(dx_q);
      sqy_q    <= SQ_W'(dy_q) * SQ_W'(dy_q);
      ss_q     <= SS_W'(sigma_eff) * SS_W'(sigma_eff);
      r2_q     <= R2_W'(sqx_q) + R2_W'(sqy_q);
      den_q    <= {ss_q, 1'b0};
      div_in_q <= div_in_d;
    end
  end

  cge_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v4_q),
    .din_i   (div_in_q),
    .valid_o (div_valid),
    .quot_o  (div_quot),
    .far_o   (div_far)
  );

  cge_exp2 u_exp2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (div_valid),
    .far_i   (div_far),
    .t_i     (div_quot),
    .amp_i   (amplitude_q),
    .valid_o (exp_valid),
    .val_o   (exp_val)
  );

  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_free) begin
      m_valid_d = exp_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && exp_valid) begin
      m_data_q <= exp_val;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

@@ dv/cge_checker.sv @@
// cge_checker: watches the pixel, result and register channels of
// circular_gaussian_eval, predicts each Gaussian value and compares it.
// Depends on cge_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module cge_checker import cge_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [2*COORD_W-1:0]  s_tdata_i,   // pos_x, pos_y
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [VAL_W-1:0]      m_tdata_i,   // value
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    err_count_o,
  output int                    pending_o
);

  typedef struct {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [VAL_W-1:0]   value;
  } pixel_value_t;

  pixel_value_t       pending_values[$];
  longint unsigned    exp2_lut [0:EXP_TABLE_DEPTH];
  logic [COORD_W-1:0] x_ctr;
  logic [COORD_W-1:0] y_ctr;
  logic [AMP_W-1:0]   amp_reg;
  logic [SIGMA_W-1:0] sigma_reg;

  // exp(-y), y and result in Q30, truncated series
  function automatic longint unsigned neg_exp_q30(input longint unsigned y);
    longint          acc;
    longint unsigned term;
    acc  = longint'(ONE_Q30);
    term = ONE_Q30;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      term = ((term * y) >> EXP_FRAC_BITS) / longint'(n);
      acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
    end
    return longint'(acc);
  endfunction

  initial begin
    longint unsigned y;
    for (int j = 0; j <= EXP_TABLE_DEPTH; j++) begin
      y = (longint'(j) * LN2_Q30 + longint'(EXP_TABLE_DEPTH / 2)) / longint'(EXP_TABLE_DEPTH);
      exp2_lut[j] = neg_exp_q30(y);
    end
  end

  function automatic logic [VAL_W-1:0] gauss_value(input logic [COORD_W-1:0] px,
                                                   input logic [COORD_W-1:0] py);
    longint unsigned dx, dy, r2, num, s, den, t, u, k, f, p, idx, w, hi, lo, m, prod;
    dx  = (px >= x_ctr) ? px - x_ctr : x_ctr - px;
    dy  = (py >= y_ctr) ? py - y_ctr : y_ctr - py;
    r2  = dx * dx + dy * dy;
    num = r2 << NUM_SHIFT;
    s   = (sigma_reg == '0) ? 64'd1 : longint'(sigma_reg);
    den = 2 * s * s;
    // far from the centre: argument of 16 or more gives zero
    if (num >= (den << T_LIMIT_BITS)) begin
      return '0;
    end
    t   = (num << Q_FRAC) / den;
    u   = (t * longint'(LOG2E_Q16) + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
    k   = u >> Q_FRAC;
    f   = u & 64'hFFFF;
    p   = f * longint'(EXP_TABLE_DEPTH);
    idx = p >> 16;
    w   = p & 64'hFFFF;
    if (idx > longint'(EXP_TABLE_DEPTH - 1)) begin
      idx = longint'(EXP_TABLE_DEPTH - 1);
    end
    hi   = exp2_lut[idx];
    lo   = exp2_lut[idx + 1];
    m    = (hi >= lo) ? hi - (((hi - lo) * w) >> 16) : hi + (((lo - hi) * w) >> 16);
    prod = longint'(amp_reg) * m;
    return VAL_W'((prod + (64'd1 << (EXP_FRAC_BITS - 1 + k))) >> (EXP_FRAC_BITS + k));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_value_t item;
    if (!rst_ni) begin
      x_ctr     = '0;
      y_ctr     = '0;
      amp_reg   = AMP_RESET;
      sigma_reg = SIGMA_RESET;
      pending_values.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_X_CENTER: begin
            x_ctr = cfg_data_i;
          end
          REG_Y_CENTER: begin
            y_ctr = cfg_data_i;
          end
          REG_AMPLITUDE: begin
            amp_reg = cfg_data_i;
          end
          REG_WIDTH_SIGMA: begin
            sigma_reg = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (pending_values.size() == 0) begin
          report_mismatch($sformatf("value %h with no pixel waiting", m_tdata_i));
        end else begin
          item = pending_values.pop_front();
          if (m_tdata_i !== item.value) begin
            report_mismatch($sformatf("pixel (%h,%h): value %h, predicted %h",
                                      item.px, item.py, m_tdata_i, item.value));
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        item.px    = s_tdata_i[COORD_W-1:0];
        item.py    = s_tdata_i[2*COORD_W-1:COORD_W];
        item.value = gauss_value(item.px, item.py);
        pending_values.insert(pending_values.size(), item);
      end
      pending_o = pending_values.size();
    end
  end

endmodule

@@ dv/circular_gaussian_eval_tb.sv @@
// circular_gaussian_eval_tb: drives pixel coordinates and register writes into
// circular_gaussian_eval with random idling and stalls; cge_checker does the
// comparison. Depends on cge_pkg, cge_checker and the block itself.
`timescale 1ns / 1ps

module circular_gaussian_eval_tb import cge_pkg::*; ();

  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_PIXELS  = 200;
  localparam int RANDOM_PHASES = 8;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [2*COORD_W-1:0]  s_axis_tdata;   // pos_x, pos_y
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [VAL_W-1:0]      m_axis_tdata;   // value
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int                 err_count;
  int                 pending;
  int                 tx_idle_pct;
  int                 rx_stall_pct;
  int                 rx_hold_len;
  int                 cycle_count;
  logic [COORD_W-1:0] cur_xc;
  logic [COORD_W-1:0] cur_yc;
  logic [SIGMA_W-1:0] cur_sigma;

  always #5 clk_i = ~clk_i;

  circular_gaussian_eval DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  cge_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // leaves cfg_valid_i high; apply_setting lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_setting(input logic [COORD_W-1:0] xc, input logic [COORD_W-1:0] yc,
                               input logic [AMP_W-1:0] amp, input logic [SIGMA_W-1:0] sig);
    write_reg(REG_X_CENTER, xc);
    write_reg(REG_Y_CENTER, yc);
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_WIDTH_SIGMA, sig);
    // out-of-range index must leave every register alone
    write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
    cur_xc    = xc;
    cur_yc    = yc;
    cur_sigma = sig;
  endtask

  // leaves s_axis_tvalid high so back-to-back items need no extra edge
  task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {py, px};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] c,
                                                    input logic [SIGMA_W-1:0] sig);
    int span;
    int v;
    span = ((sig == '0) ? 1 : int'(sig)) * 6 / 16 + 2;
    v    = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) begin
      v = 0;
    end else if (v > 65535) begin
      v = 65535;
    end
    return COORD_W'(v);
  endfunction

  // result side
  initial begin
    int hold_cycles;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_len != 0) begin
        hold_cycles = rx_hold_len;
        rx_hold_len = 0;
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    tx_idle_pct   = 0;
    rx_stall_pct  = 5;
    rx_hold_len   = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: centre at origin, amplitude and sigma both 256
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'h0010, 16'h0000);
    drain();

    apply_setting(16'h0400, 16'h0400, 16'hFFFF, 16'h0100);
    send_pixel(16'h0400, 16'h0400);
    send_pixel(16'h0401, 16'h0400);
    send_pixel(16'h0440, 16'h0440);
    send_pixel(16'h0440, 16'h043F);
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'h0000, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000);
    drain();

    apply_setting(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_pixel(16'h0000, 16'hFFFF);
    send_pixel(16'h1234, 16'hF000);
    drain();

    // zero sigma behaves as one lsb
    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFE, 16'hFFFF);
    drain();

    apply_setting(16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'h9000, 16'h8000);
    send_pixel(16'h8000, 16'h8000);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: apply_setting(16'h0000, 16'h0000, 16'hFFFF, 16'h0001);
        1: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: apply_setting(COORD_W'($urandom), COORD_W'($urandom), AMP_W'($urandom), 16'h0000);
        default: apply_setting(COORD_W'($urandom), COORD_W'($urandom),
                               AMP_W'($urandom_range(1, 65535)),
                               SIGMA_W'($urandom_range(1, 4096)));
      endcase
      if (ph >= RANDOM_PHASES - 2) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end else begin
        tx_idle_pct  = 10 * $urandom_range(0, 3);
        rx_stall_pct = 5 * $urandom_range(0, 3);
      end
      // long result stall with the sender pushing until the input backs up
      if (ph == 3) begin
        tx_idle_pct = 0;
        rx_hold_len = 300;
      end
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (ph == 4 && n == PHASE_PIXELS / 2) begin
          drain();
        end
        if ($urandom_range(0, 4) == 0) begin
          send_pixel(COORD_W'($urandom), COORD_W'($urandom));
        end else begin
          send_pixel(near_coord(cur_xc, cur_sigma), near_coord(cur_yc, cur_sigma));
        end
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
